// ===== src/segment_segment_intersect_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef SEGMENT_SEGMENT_INTERSECT_UNIT_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECT_UNIT_ASSERT_SVH

// checked while out of reset
`define SSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssi assertion failed");

// checked also across reset
`define SSI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssi reset assertion failed");

`endif

// ===== src/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg
// shared constants, register indexes and control types
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAY_START_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAY_START_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAY_END_X   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAY_END_Y   = 3'd3;

  typedef struct packed {
    logic valid;
    logic hit;
  } ssi_ctl_t;

endpackage

// ===== src/ssi_front.sv =====
// ----------------------------------------------------------------------------
// ssi_front
// differences, cross products, range test and quotient numerators
// ----------------------------------------------------------------------------
module ssi_front #(
  parameter int W = ssi_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   x3,
  input  logic signed [W-1:0]   y3,
  input  logic signed [W-1:0]   x4,
  input  logic signed [W-1:0]   y4,
  input  logic signed [W-1:0]   x1,
  input  logic signed [W-1:0]   y1,
  input  logic signed [W-1:0]   x2,
  input  logic signed [W-1:0]   y2,
  output ssi_pkg::ssi_ctl_t     ctl_o,
  output logic [2*W:0]          den_o,
  output logic [3*W:0]          num_x_o,
  output logic [3*W:0]          num_y_o
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int MW = 2 * W + 1;
  localparam int NW = 3 * W + 1;
  localparam int H  = (MW + 1) / 2;
  localparam int HW = MW - H;

  logic signed [DW-1:0] ex1, ey1, ex2, ey2;
  logic signed [DW-1:0] d12x, d12y, rdx, rdy, rdx_abs, rdy_abs;
  logic [W-1:0]         rdx_mag, rdy_mag;

  logic [5:0]           v_r;
  logic                 hit4_r;

  logic signed [DW-1:0] d34x_r, d34y_r, d13x_r, d13y_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [SW-1:0] den_r, tn_r, un_r;
  logic signed [SW-1:0] den_n, tn_n, un_n;
  logic                 hit_nxt;
  logic [MW-1:0]        den4_r, tn4_r, den5_r, den6_r;
  logic [H+W-1:0]       pxl_r, pyl_r;
  logic [HW+W-1:0]      pxh_r, pyh_r;
  logic                 hit5_r, hit6_r;
  logic [NW-1:0]        numx_r, numy_r;

  assign ex1 = {x1[W-1], x1};
  assign ey1 = {y1[W-1], y1};
  assign ex2 = {x2[W-1], x2};
  assign ey2 = {y2[W-1], y2};
  assign d12x = ex1 - ex2;
  assign d12y = ey1 - ey2;
  assign rdx  = ex2 - ex1;
  assign rdy  = ey2 - ey1;
  assign rdx_abs = rdx[DW-1] ? -rdx : rdx;
  assign rdy_abs = rdy[DW-1] ? -rdy : rdy;
  assign rdx_mag = rdx_abs[W-1:0];
  assign rdy_mag = rdy_abs[W-1:0];

  assign den_n = den_r[SW-1] ? -den_r : den_r;
  assign tn_n  = den_r[SW-1] ? -tn_r  : tn_r;
  assign un_n  = den_r[SW-1] ? -un_r  : un_r;
  assign hit_nxt = (den_r != '0) && !tn_n[SW-1] && !un_n[SW-1] &&
                   (tn_n <= den_n) && (un_n <= den_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d34x_r <= $signed({x3[W-1], x3}) - $signed({x4[W-1], x4});
      d34y_r <= $signed({y3[W-1], y3}) - $signed({y4[W-1], y4});
      d13x_r <= ex1 - $signed({x3[W-1], x3});
      d13y_r <= ey1 - $signed({y3[W-1], y3});
      pa_r   <= d12x * d34y_r;
      pb_r   <= d12y * d34x_r;
      pc_r   <= d13x_r * d34y_r;
      pd_r   <= d13y_r * d34x_r;
      pe_r   <= rdx * d13y_r;
      pf_r   <= rdy * d13x_r;
      den_r  <= SW'(pa_r) - SW'(pb_r);
      tn_r   <= SW'(pc_r) - SW'(pd_r);
      un_r   <= SW'(pe_r) - SW'(pf_r);
      hit4_r <= hit_nxt;
      den4_r <= den_n[MW-1:0];
      tn4_r  <= tn_n[MW-1:0];
      hit5_r <= hit4_r;
      den5_r <= den4_r;
      pxl_r  <= tn4_r[H-1:0] * rdx_mag;
      pxh_r  <= tn4_r[MW-1:H] * rdx_mag;
      pyl_r  <= tn4_r[H-1:0] * rdy_mag;
      pyh_r  <= tn4_r[MW-1:H] * rdy_mag;
      hit6_r <= hit5_r;
      den6_r <= den5_r;
      numx_r <= NW'(pxl_r) + (NW'(pxh_r) << H);
      numy_r <= NW'(pyl_r) + (NW'(pyh_r) << H);
    end
  end

  assign ctl_o.valid = v_r[5];
  assign ctl_o.hit   = hit6_r;
  assign den_o   = den6_r;
  assign num_x_o = numx_r;
  assign num_y_o = numy_r;

endmodule

// ===== src/ssi_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssi_div_cell
// one restoring divide step, one quotient bit for x and for y
// ----------------------------------------------------------------------------
module ssi_div_cell #(
  parameter int MW    = 65,
  parameter int NW    = 97,
  parameter int QW    = 32,
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ssi_pkg::ssi_ctl_t ctl_i,
  input  logic [MW-1:0]     den_i,
  input  logic [NW-1:0]     rx_i,
  input  logic [NW-1:0]     ry_i,
  input  logic [QW-1:0]     qx_i,
  input  logic [QW-1:0]     qy_i,
  output ssi_pkg::ssi_ctl_t ctl_o,
  output logic [MW-1:0]     den_o,
  output logic [NW-1:0]     rx_o,
  output logic [NW-1:0]     ry_o,
  output logic [QW-1:0]     qx_o,
  output logic [QW-1:0]     qy_o
);

  logic [NW-1:0]     dsh;
  logic              gex, gey;
  ssi_pkg::ssi_ctl_t ctl_r;
  logic [MW-1:0]     den_r;
  logic [NW-1:0]     rx_r, ry_r;
  logic [QW-1:0]     qx_r, qy_r;

  assign dsh = NW'(den_i) << SHIFT;
  assign gex = rx_i >= dsh;
  assign gey = ry_i >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rx_r  <= gex ? rx_i - dsh : rx_i;
      ry_r  <= gey ? ry_i - dsh : ry_i;
      qx_r  <= qx_i | ({{(QW-1){1'b0}}, gex} << SHIFT);
      qy_r  <= qy_i | ({{(QW-1){1'b0}}, gey} << SHIFT);
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;

endmodule

// ===== src/segment_segment_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// segment_segment_intersect_unit
// intersection of streamed wall segments with one configured ray segment
// ----------------------------------------------------------------------------
// the ray endpoints sit in four registers written over the cfg port (index
// 0..3: start x, start y, end x, end y); write them only while the unit is
// empty. each wall segment transfer on the in_ channel gives exactly one
// result transfer on the out_ channel, in order: out_hit and the crossing
// point, or zero coordinates when the segments miss or are parallel.
// throughput is one segment per cycle while in_stall is low; the pipeline is
// six front stages for differences, products, range test and numerator
// partial products, then a chain of COORD_WIDTH divide cells giving one
// quotient bit each, then the output register.
// the whole pipeline advances together; in_stall rises only while a result
// waits in the output register under out_stall, so new segments are taken
// as long as the output register is empty or being drained.
// synchronous reset clears the ray registers to zero and empties the
// pipeline; no result is shown in the cycle after reset.
// ----------------------------------------------------------------------------
module segment_segment_intersect_unit #(
  parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ssi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_seg_start_x,
  input  logic signed [COORD_WIDTH-1:0]        in_seg_start_y,
  input  logic signed [COORD_WIDTH-1:0]        in_seg_end_x,
  input  logic signed [COORD_WIDTH-1:0]        in_seg_end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic signed [COORD_WIDTH-1:0]        out_cross_x,
  output logic signed [COORD_WIDTH-1:0]        out_cross_y
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = 2 * W + 1;
  localparam int NW = 3 * W + 1;

  logic signed [W-1:0] rsx_r, rsy_r, rex_r, rey_r;
  logic                en;
  logic                negx, negy;

  ssi_pkg::ssi_ctl_t ctl_w [W+1];
  logic [MW-1:0]     den_w [W+1];
  logic [NW-1:0]     rx_w  [W+1];
  logic [NW-1:0]     ry_w  [W+1];
  logic [W-1:0]      qx_w  [W+1];
  logic [W-1:0]      qy_w  [W+1];

  logic [W-1:0]        sx, sy;
  logic                out_valid_r, out_hit_r;
  logic signed [W-1:0] out_x_r, out_y_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsx_r <= '0;
      rsy_r <= '0;
      rex_r <= '0;
      rey_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssi_pkg::REG_RAY_START_X: rsx_r <= cfg_data;
        ssi_pkg::REG_RAY_START_Y: rsy_r <= cfg_data;
        ssi_pkg::REG_RAY_END_X:   rex_r <= cfg_data;
        ssi_pkg::REG_RAY_END_Y:   rey_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ssi_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .x3       (in_seg_start_x),
    .y3       (in_seg_start_y),
    .x4       (in_seg_end_x),
    .y4       (in_seg_end_y),
    .x1       (rsx_r),
    .y1       (rsy_r),
    .x2       (rex_r),
    .y2       (rey_r),
    .ctl_o    (ctl_w[0]),
    .den_o    (den_w[0]),
    .num_x_o  (rx_w[0]),
    .num_y_o  (ry_w[0])
  );

  assign qx_w[0] = '0;
  assign qy_w[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    ssi_div_cell #(
      .MW    (MW),
      .NW    (NW),
      .QW    (W),
      .SHIFT (W - 1 - k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_w[k]),
      .den_i (den_w[k]),
      .rx_i  (rx_w[k]),
      .ry_i  (ry_w[k]),
      .qx_i  (qx_w[k]),
      .qy_i  (qy_w[k]),
      .ctl_o (ctl_w[k+1]),
      .den_o (den_w[k+1]),
      .rx_o  (rx_w[k+1]),
      .ry_o  (ry_w[k+1]),
      .qx_o  (qx_w[k+1]),
      .qy_o  (qy_w[k+1])
    );
  end

  // quotient sign follows the ray direction, t is never negative here
  assign negx = rex_r < rsx_r;
  assign negy = rey_r < rsy_r;
  assign sx = negx ? W'(0) - qx_w[W] : qx_w[W];
  assign sy = negy ? W'(0) - qy_w[W] : qy_w[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_w[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= ctl_w[W].hit;
      out_x_r   <= ctl_w[W].hit ? W'(rsx_r + sx) : '0;
      out_y_r   <= ctl_w[W].hit ? W'(rsy_r + sy) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

endmodule

// ===== src/ssi_checker.sv =====
// ----------------------------------------------------------------------------
// ssi_checker
// port-level checks on the intersect unit, bound to the top level
// ----------------------------------------------------------------------------
`include "segment_segment_intersect_unit_assert.svh"

module ssi_checker #(
  parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_hit,
  input logic [COORD_WIDTH-1:0] out_cross_x,
  input logic [COORD_WIDTH-1:0] out_cross_y
);

  // a miss carries a zero point
  `SSI_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
  // input side only held back by a waiting result
  `SSI_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
  // stalled result holds
  `SSI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cross_x) && $stable(out_hit))
  // empty after reset
  `SSI_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind segment_segment_intersect_unit ssi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_hit     (out_hit),
  .out_cross_x (out_cross_x),
  .out_cross_y (out_cross_y)
);
